### rtl/button_short_long_press_detector_unit_assert.svh
// Assertion macros used by the checker module of the button press detector.
`ifndef BUTTON_SHORT_LONG_PRESS_DETECTOR_UNIT_ASSERT_SVH
`define BUTTON_SHORT_LONG_PRESS_DETECTOR_UNIT_ASSERT_SVH

// Property that must hold at every rising clock edge outside reset.
`define BSLD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bsld assertion failed");

// Condition that must never be true outside reset.
`define BSLD_ASSERT_NEVER(label, clk, rst_n, cond) \
  `BSLD_ASSERT(label, clk, rst_n, !(cond))

`endif

### rtl/bsld_pkg.sv
// ----------------------------------------------------------------------------
// Button press detector package
// Timer width, register indexes and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package bsld_pkg;

  localparam int TimerBits = 16;
  localparam int RegBits   = 16;
  localparam int IdxBits   = 2;

  localparam logic [32:0] TimerMax = (33'd1 << TimerBits) - 33'd1;

  typedef logic [TimerBits-1:0] timer_t;

  typedef enum logic [IdxBits-1:0] {
    RegDebounceTicks  = 2'd0,
    RegLongPressTicks = 2'd1,
    RegInputsEnabled  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic stable_pressed;
  } res_t;

  // A zero delay acts as one; a delay above the timer range saturates.
  function automatic timer_t load_value(input logic [RegBits-1:0] r);
    logic [32:0] v;
    v = {{(33-RegBits){1'b0}}, r};
    if (v == 33'd0) begin
      v = 33'd1;
    end
    if (v > TimerMax) begin
      v = TimerMax;
    end
    return v[TimerBits-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/button_short_long_press_detector_unit.sv
// ----------------------------------------------------------------------------
// Button short/long press detector
// Debounces one raw button sample per word and reports short and long presses.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i/in_ready_o) carries one raw_level word
// per millisecond tick. Every accepted word yields exactly one result word on
// the output channel (out_valid_o/out_ready_i) with short_press, long_press
// and stable_pressed. The state update is a single pass of counter and flag
// logic, so the result is registered on acceptance and a new word can be taken
// in every cycle while the skid is empty. Results pass through an output
// register backed by one skid register: when the receiver stalls, one more
// word is still taken, then in_ready_o drops until the output register drains.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes the debounce
// delay, the hold time and the pulse enable; write it only while the block is
// idle. Reset clears the counters and flags, sets the delays to 20 and 3000
// ticks and disables the pulses. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module button_short_long_press_detector_unit import bsld_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [IdxBits-1:0] cfg_idx_i,
  input  wire logic [RegBits-1:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               raw_level_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    short_press_o,
  output logic                    long_press_o,
  output logic                    stable_pressed_o
);

  // Configuration registers.
  logic [RegBits-1:0] debounce_ticks_q;
  logic [RegBits-1:0] long_press_ticks_q;
  logic               inputs_enabled_q;

  // Detector state.
  logic   last_raw_q, last_raw_d;
  timer_t debounce_left_q, debounce_left_d;
  logic   debounce_armed_q, debounce_armed_d;
  logic   settled_q, settled_d;
  timer_t hold_left_q, hold_left_d;
  logic   hold_armed_q, hold_armed_d;
  logic   long_marked_q, long_marked_d;

  // Output register and skid register.
  res_t res_d;
  res_t out_q;
  res_t skid_q;
  logic out_valid_q;
  logic skid_valid_q;

  logic in_fire;
  logic hold_loaded;
  timer_t deb_dec;
  timer_t hold_dec;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q   <= RegBits'(20);
      long_press_ticks_q <= RegBits'(3000);
      inputs_enabled_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegDebounceTicks:  debounce_ticks_q   <= cfg_wdata_i;
        RegLongPressTicks: long_press_ticks_q <= cfg_wdata_i;
        RegInputsEnabled:  inputs_enabled_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign deb_dec = debounce_left_q - timer_t'(1);

  always_comb begin
    last_raw_d       = raw_level_i;
    debounce_left_d  = debounce_left_q;
    debounce_armed_d = debounce_armed_q;
    settled_d        = settled_q;
    hold_left_d      = hold_left_q;
    hold_armed_d     = hold_armed_q;
    long_marked_d    = long_marked_q;
    hold_loaded      = 1'b0;
    res_d            = '0;

    if (raw_level_i != last_raw_q) begin
      debounce_left_d  = load_value(debounce_ticks_q);
      debounce_armed_d = 1'b1;
    end else if (debounce_armed_q) begin
      debounce_left_d = deb_dec;
      if (deb_dec == '0) begin
        debounce_armed_d = 1'b0;
        if (raw_level_i != settled_q) begin
          settled_d = raw_level_i;
          if (raw_level_i) begin
            long_marked_d = 1'b0;
            hold_left_d   = load_value(long_press_ticks_q);
            hold_armed_d  = 1'b1;
            hold_loaded   = 1'b1;
          end else begin
            hold_armed_d      = 1'b0;
            hold_left_d       = '0;
            res_d.short_press = !long_marked_q && inputs_enabled_q;
          end
        end
      end
    end

    // The hold countdown runs on the value left by the debounce step.
    if (hold_armed_d && !hold_loaded) begin
      hold_left_d = hold_dec;
      if (hold_dec == '0) begin
        hold_armed_d = 1'b0;
        if (settled_d && !long_marked_d && raw_level_i) begin
          long_marked_d    = 1'b1;
          res_d.long_press = inputs_enabled_q;
        end
      end
    end

    res_d.stable_pressed = settled_d;
  end

  // Only the old hold value can be decremented: a fresh load skips the step.
  assign hold_dec = hold_left_q - timer_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q       <= 1'b0;
      debounce_left_q  <= '0;
      debounce_armed_q <= 1'b0;
      settled_q        <= 1'b0;
      hold_left_q      <= '0;
      hold_armed_q     <= 1'b0;
      long_marked_q    <= 1'b0;
    end else if (in_fire) begin
      last_raw_q       <= last_raw_d;
      debounce_left_q  <= debounce_left_d;
      debounce_armed_q <= debounce_armed_d;
      settled_q        <= settled_d;
      hold_left_q      <= hold_left_d;
      hold_armed_q     <= hold_armed_d;
      long_marked_q    <= long_marked_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res_d;
      end
    end else if (in_fire) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign short_press_o    = out_q.short_press;
  assign long_press_o     = out_q.long_press;
  assign stable_pressed_o = out_q.stable_pressed;

endmodule

`default_nettype wire

### rtl/bsld_checker.sv
// ----------------------------------------------------------------------------
// Button press detector checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_short_long_press_detector_unit_assert.svh"

module bsld_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic short_press_o,
  input wire logic long_press_o,
  input wire logic stable_pressed_o
);

  // A stalled result word keeps its payload.
  `BSLD_ASSERT(a_out_hold, clk_i, rst_ni,
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(short_press_o)
      && $stable(long_press_o) && $stable(stable_pressed_o)))

  // A short press is reported on the release, so the settled level is released.
  `BSLD_ASSERT_NEVER(a_short_released, clk_i, rst_ni,
    out_valid_o && short_press_o && stable_pressed_o)

  // A long press fires only while the button is held.
  `BSLD_ASSERT_NEVER(a_long_pressed, clk_i, rst_ni,
    out_valid_o && long_press_o && !stable_pressed_o)

  // Both pulses never come in the same word.
  `BSLD_ASSERT_NEVER(a_one_pulse, clk_i, rst_ni,
    out_valid_o && short_press_o && long_press_o)

endmodule

bind button_short_long_press_detector_unit bsld_checker u_bsld_checker (.*);

`default_nettype wire

### sim/button_short_long_press_detector_unit_tb.sv
// ----------------------------------------------------------------------------
// Button short/long press detector testbench
// Sends raw button levels and checks every result word against a cycle-free
// model of the debounce and hold timers. A short directed table comes first.
// Random press sequences follow under several timer settings and idle
// patterns on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module button_short_long_press_detector_unit_tb;
  import bsld_pkg::*;

  localparam logic [IdxBits-1:0] RegSpareIdx = 2'd3;
  localparam int HoldOff       = 4;
  localparam int StallLimit    = 5000;
  localparam int WordsPerPhase = 88;
  localparam int NumRows       = 32;

  typedef enum logic {RowWord, RowWrite} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic               lvl;
    logic               typed;
    res_t               want;
    logic [IdxBits-1:0] idx;
    logic [RegBits-1:0] val;
  } plan_row_t;

  // Typed results hold only right after reset, with the delays still at 20 and 3000.
  localparam plan_row_t Plan [NumRows] = '{
    '{RowWord,  1'b0, 1'b1, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWord,  1'b1, 1'b1, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWord,  1'b0, 1'b1, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWrite, 1'b0, 1'b0, 3'b000, RegSpareIdx, 16'hFFFF},
    '{RowWrite, 1'b0, 1'b0, 3'b000, RegDebounceTicks, 16'h0000},
    '{RowWrite, 1'b0, 1'b0, 3'b000, RegLongPressTicks, 16'h0001},
    '{RowWrite, 1'b0, 1'b0, 3'b000, RegInputsEnabled, 16'hFFFF},
    // Long press, then release without a short pulse.
    '{RowWord,  1'b1, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWord,  1'b1, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWord,  1'b1, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWord,  1'b1, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWord,  1'b0, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWord,  1'b0, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    // Short press: the hold runs out on the raw release word.
    '{RowWord,  1'b1, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWord,  1'b1, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWord,  1'b0, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWord,  1'b0, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    // Bouncing pin never settles.
    '{RowWord,  1'b1, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWord,  1'b0, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWord,  1'b1, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWord,  1'b0, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    // Pulses suppressed while the pulse enable bit is cleared.
    '{RowWrite, 1'b0, 1'b0, 3'b000, RegInputsEnabled, 16'hFFFE},
    '{RowWord,  1'b1, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWord,  1'b1, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWord,  1'b1, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWord,  1'b0, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWord,  1'b0, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWrite, 1'b0, 1'b0, 3'b000, RegInputsEnabled, 16'h0001},
    '{RowWrite, 1'b0, 1'b0, 3'b000, RegDebounceTicks, 16'hFFFF},
    '{RowWrite, 1'b0, 1'b0, 3'b000, RegLongPressTicks, 16'hFFFF},
    '{RowWord,  1'b1, 1'b0, 3'b000, RegSpareIdx, 16'h0000},
    '{RowWord,  1'b0, 1'b0, 3'b000, RegSpareIdx, 16'h0000}
  };

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [IdxBits-1:0] cfg_idx;
  logic [RegBits-1:0] cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic               raw_level;
  logic               out_valid;
  logic               out_ready;
  logic               short_press;
  logic               long_press;
  logic               stable_pressed;

  // Travels with each word so the monitor sees it with the word's own edge.
  logic word_typed;
  res_t word_fixed;

  int idle_pct;
  int stall_pct;
  int words_sent;
  int mismatches;
  int quiet_cycles;

  res_t press_results_due [$];

  // Detector model: configuration copy and state.
  logic [RegBits-1:0] cfg_debounce = 16'd20;
  logic [RegBits-1:0] cfg_hold     = 16'd3000;
  logic               cfg_enable   = 1'b0;
  logic               prev_lvl     = 1'b0;
  timer_t             bounce_cnt   = '0;
  logic               bounce_live  = 1'b0;
  logic               level_q      = 1'b0;
  timer_t             hold_cnt     = '0;
  logic               hold_live    = 1'b0;
  logic               long_seen    = 1'b0;

  button_short_long_press_detector_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .raw_level_i     (raw_level),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .short_press_o   (short_press),
    .long_press_o    (long_press),
    .stable_pressed_o(stable_pressed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A delay of zero counts as one tick.
  function automatic timer_t delay_load(input logic [RegBits-1:0] r);
    return (r == '0) ? timer_t'(1) : timer_t'(r);
  endfunction

  function automatic res_t step_detector(input logic lvl);
    res_t r;
    logic just_loaded;
    r = '0;
    just_loaded = 1'b0;
    if (lvl != prev_lvl) begin
      bounce_cnt = delay_load(cfg_debounce);
      bounce_live = 1'b1;
    end else if (bounce_live) begin
      bounce_cnt = bounce_cnt - 1'b1;
      if (bounce_cnt == '0) begin
        bounce_live = 1'b0;
        if (lvl != level_q) begin
          level_q = lvl;
          if (lvl) begin
            long_seen = 1'b0;
            hold_cnt = delay_load(cfg_hold);
            hold_live = 1'b1;
            just_loaded = 1'b1;
          end else begin
            hold_live = 1'b0;
            hold_cnt = '0;
            r.short_press = !long_seen && cfg_enable;
          end
        end
      end
    end
    prev_lvl = lvl;
    // The hold timer does not count on the tick that loads it.
    if (hold_live && !just_loaded) begin
      hold_cnt = hold_cnt - 1'b1;
      if (hold_cnt == '0) begin
        hold_live = 1'b0;
        if (level_q && !long_seen && lvl) begin
          long_seen = 1'b1;
          r.long_press = cfg_enable;
        end
      end
    end
    r.stable_pressed = level_q;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic send_word(input logic lvl, input logic typed, input res_t fixed);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid   <= 1'b1;
    raw_level  <= lvl;
    word_typed <= typed;
    word_fixed <= fixed;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (press_results_due.size() != 0) @(posedge clk);
    repeat (HoldOff) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IdxBits-1:0] idx, input logic [RegBits-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      RegDebounceTicks:  cfg_debounce = val;
      RegLongPressTicks: cfg_hold = val;
      RegInputsEnabled:  cfg_enable = val[0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    res_t want;
    logic took_in;
    logic took_out;
    if (rst_n) begin
      took_in  = in_valid && in_ready;
      took_out = out_valid && out_ready;
      if (took_in) begin
        want = step_detector(raw_level);
        press_results_due.push_back(word_typed ? word_fixed : want);
      end
      if (took_out) begin
        if (press_results_due.size() == 0) begin
          report_mismatch("result word with no input word outstanding");
        end else begin
          want = press_results_due.pop_front();
          if (short_press !== want.short_press) begin
            report_mismatch($sformatf("short_press %b, want %b", short_press,
                                      want.short_press));
          end
          if (long_press !== want.long_press) begin
            report_mismatch($sformatf("long_press %b, want %b", long_press,
                                      want.long_press));
          end
          if (stable_pressed !== want.stable_pressed) begin
            report_mismatch($sformatf("stable_pressed %b, want %b", stable_pressed,
                                      want.stable_pressed));
          end
        end
      end
      quiet_cycles = (took_in || took_out) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("timeout: no word moved for %0d cycles", StallLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    logic [RegBits-1:0] deb;
    logic [RegBits-1:0] hold;
    int deb_eff;
    int hold_eff;
    int run;
    int phase_end;
    idle_pct     = 0;
    stall_pct    = 0;
    words_sent   = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_idx    <= RegDebounceTicks;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    raw_level  <= 1'b0;
    out_ready  <= 1'b0;
    word_typed <= 1'b0;
    word_fixed <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumRows; i++) begin
      if (Plan[i].kind == RowWrite) begin
        quiesce();
        write_reg(Plan[i].idx, Plan[i].val);
      end else begin
        send_word(Plan[i].lvl, Plan[i].typed, Plan[i].want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      quiesce();
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      deb  = ($urandom_range(0, 7) == 0) ? '0 : RegBits'($urandom_range(1, 6));
      hold = ($urandom_range(0, 4) == 0) ? RegBits'($urandom_range(25, 60))
                                         : RegBits'($urandom_range(0, 14));
      write_reg(RegDebounceTicks, deb);
      write_reg(RegLongPressTicks, hold);
      write_reg(RegInputsEnabled, {15'($urandom), 1'($urandom_range(0, 3) != 0)});
      if ($urandom_range(0, 3) == 0) begin
        write_reg(RegSpareIdx, 16'($urandom));
      end
      deb_eff   = (deb == '0) ? 1 : int'(deb);
      hold_eff  = (hold == '0) ? 1 : int'(hold);
      phase_end = words_sent + WordsPerPhase;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 8)) send_word(1'($urandom), 1'b0, '0);
        end else begin
          // Contact bounce, a held press of varying length, bounce, then a settled release.
          repeat ($urandom_range(0, 3)) send_word(1'($urandom), 1'b0, '0);
          case ($urandom_range(0, 2))
            0: run = $urandom_range(1, deb_eff);
            1: run = deb_eff + $urandom_range(0, hold_eff);
            default: run = deb_eff + hold_eff + $urandom_range(0, 4);
          endcase
          repeat (run) send_word(1'b1, 1'b0, '0);
          repeat ($urandom_range(0, 3)) send_word(1'($urandom), 1'b0, '0);
          repeat (deb_eff + $urandom_range(1, 4)) send_word(1'b0, 1'b0, '0);
        end
      end
    end

    quiesce();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
